FILE: hw/rtl/qfms_pkg.sv
// ----------------------------------------------------------------------------
// Quad flight mode supervisor package
// Mode, command, message and register codes, together with the reset values
// and fixed widths shared by the supervisor logic.
// ----------------------------------------------------------------------------
package qfms_pkg;

    typedef enum logic [2:0] {
        MODE_INIT       = 3'd0,
        MODE_DISARMED   = 3'd1,
        MODE_ARMING     = 3'd2,
        MODE_ARMING_MAN = 3'd3,
        MODE_FLYING     = 3'd4,
        MODE_EMERGENCY  = 3'd5,
        MODE_CALIBRATE  = 3'd6,
        MODE_MANUAL     = 3'd7
    } mode_t;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_MSG    = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    localparam logic [3:0] MSG_HEARTBEAT = 4'd0;
    localparam logic [3:0] MSG_BIAS      = 4'd1;
    localparam logic [3:0] MSG_STOP      = 4'd2;
    localparam logic [3:0] MSG_ESTOP     = 4'd3;
    localparam logic [3:0] MSG_START     = 4'd4;
    localparam logic [3:0] MSG_RESET     = 4'd5;
    localparam logic [3:0] MSG_CALIBRATE = 4'd6;
    localparam logic [3:0] MSG_CONFIG    = 4'd8;
    localparam logic [3:0] MSG_MANUAL    = 4'd9;
    localparam logic [3:0] MSG_THROTTLE  = 4'd11;

    localparam logic [1:0] CFG_HB_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_ARM_DELAY  = 2'd1;
    localparam logic [1:0] CFG_MIN_THR    = 2'd2;
    localparam logic [1:0] CFG_MAX_THR    = 2'd3;

    localparam int FRAC_BITS = 14;

    localparam logic [15:0]        HB_TIMEOUT_RST = 16'd2000;
    localparam logic [15:0]        ARM_DELAY_RST  = 16'd2500;
    localparam logic [14:0]        MIN_THR_RST    = 15'd819;
    localparam logic [14:0]        MAX_THR_RST    = 15'd16384;
    localparam logic signed [15:0] BASE_THR_RST   = 16'sd1638;

    localparam logic [16:0] HB_MAX      = 17'h1FFFF;
    localparam logic [15:0] ARM_MAX     = 16'hFFFF;
    localparam logic [9:0]  MOTOR_SCALE = 10'd1000;
    localparam logic [9:0]  CMD_MAX     = 10'd1001;

    localparam int S_TDATA_W = 128;
    localparam int S_TUSER_W = 6;
    localparam int M_TDATA_W = 48;

endpackage

FILE: hw/rtl/quad_flight_mode_supervisor_unit.sv
// ----------------------------------------------------------------------------
// Quad flight mode supervisor
// Usage: events enter on the s_ stream as one word each: a millisecond tick,
// a decoded radio message or a control sample, chosen by the command field
// in s_tuser. Every accepted word gives exactly one result word on the m_
// stream, carrying the mode, the running flag and the four motor commands
// as they stand after that event.
// The cfg_ channel writes the four limit registers; it is always ready and
// is meant to be used only while no event is in flight.
// From acceptance the word passes through the input register and then the
// state update, whose mix, clamp and scale by 1000 form the longest path
// and whose registers present the result. One word is accepted every cycle
// while the receiver takes each result.
// When the receiver stalls, the result is held in the state registers, the
// input register fills and s_tready falls until the result is taken.
// Reset brings the block to init mode with zero biases, stopped motors, a
// base throttle of 0.10 and the default limits, with both streams empty.
// ----------------------------------------------------------------------------
module quad_flight_mode_supervisor_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // bias_one, bias_two, bias_three, bias_four, throttle_value,
    // pitch_correction, roll_correction, yaw_correction
    input  logic [qfms_pkg::S_TDATA_W-1:0] s_tdata,
    // command, msg_type
    input  logic [qfms_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // mode, motors_running, motor_one_cmd, motor_two_cmd, motor_three_cmd,
    // motor_four_cmd, zero padding
    output logic [qfms_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [15:0]                    cfg_data
);

    import qfms_pkg::*;

    logic                  in_valid_reg;
    logic [S_TDATA_W-1:0]  in_data_reg;
    logic [S_TUSER_W-1:0]  in_user_reg;
    logic                  out_valid_reg;
    logic                  advance;

    logic [15:0] hb_timeout_reg;
    logic [15:0] arm_delay_reg;
    logic [14:0] min_thr_reg;
    logic [14:0] max_thr_reg;

    mode_t              mode_reg, mode_next;
    logic [16:0]        hb_reg, hb_next, hb_inc;
    logic [15:0]        arm_reg, arm_next, arm_inc;
    logic signed [15:0] bias_reg [4];
    logic signed [15:0] bias_next [4];
    logic signed [15:0] base_thr_reg, base_thr_next;
    logic [9:0]         motor_reg [4];
    logic [9:0]         motor_next [4];
    logic               run_reg, run_next;

    logic               stop_req, start_req, sample_drive;
    logic [1:0]         in_cmd;
    logic [3:0]         in_msg;
    logic signed [15:0] in_bias [4];
    logic signed [15:0] in_thr, in_pitch, in_roll, in_yaw;
    logic signed [17:0] thr_s, pitch_s, roll_s, yaw_s;
    logic signed [17:0] mix [4];

    function automatic logic [9:0] scale_one(input logic signed [17:0] s);
        logic signed [17:0] v;
        logic [24:0]        prod;
        logic [24:0]        c;
        v = s;
        if (v > $signed({3'b000, max_thr_reg})) begin
            v = $signed({3'b000, max_thr_reg});
        end
        if (v < $signed({3'b000, min_thr_reg})) begin
            v = $signed({3'b000, min_thr_reg});
        end
        prod = 25'(v[14:0]) * 25'(MOTOR_SCALE);
        c    = (prod >> FRAC_BITS) + 25'd1;
        return (c > 25'(CMD_MAX)) ? CMD_MAX : c[9:0];
    endfunction

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign cfg_ready = 1'b1;

    assign m_tdata = {4'b0000, motor_reg[3], motor_reg[2], motor_reg[1], motor_reg[0],
                      run_reg, mode_reg};

    assign in_cmd   = in_user_reg[1:0];
    assign in_msg   = in_user_reg[5:2];
    assign in_thr   = in_data_reg[79:64];
    assign in_pitch = in_data_reg[95:80];
    assign in_roll  = in_data_reg[111:96];
    assign in_yaw   = in_data_reg[127:112];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            in_bias[i] = in_data_reg[16*i +: 16];
        end
    end

    assign hb_inc  = (hb_reg != HB_MAX) ? hb_reg + 17'd1 : hb_reg;
    assign arm_inc = (arm_reg != ARM_MAX) ? arm_reg + 16'd1 : arm_reg;

    always_comb begin
        mode_next     = mode_reg;
        hb_next       = hb_reg;
        arm_next      = arm_reg;
        bias_next     = bias_reg;
        base_thr_next = base_thr_reg;
        stop_req      = 1'b0;
        start_req     = 1'b0;
        sample_drive  = 1'b0;
        case (in_cmd)
            CMD_TICK: begin
                case (mode_reg)
                    MODE_INIT, MODE_CALIBRATE: begin
                        mode_next = MODE_DISARMED;
                    end
                    MODE_ARMING, MODE_ARMING_MAN: begin
                        arm_next = arm_inc;
                        if (arm_inc >= arm_delay_reg) begin
                            mode_next = (mode_reg == MODE_ARMING) ? MODE_FLYING : MODE_MANUAL;
                            hb_next   = '0;
                        end
                    end
                    MODE_FLYING, MODE_MANUAL: begin
                        hb_next = hb_inc;
                        if (hb_inc > {1'b0, hb_timeout_reg}) begin
                            stop_req  = 1'b1;
                            mode_next = MODE_EMERGENCY;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_MSG: begin
                case (mode_reg)
                    MODE_DISARMED: begin
                        case (in_msg)
                            MSG_START: begin
                                base_thr_next = '0;
                                arm_next      = '0;
                                start_req     = 1'b1;
                                mode_next     = MODE_ARMING;
                            end
                            MSG_RESET: begin
                                mode_next = MODE_INIT;
                            end
                            MSG_CALIBRATE: begin
                                mode_next = MODE_CALIBRATE;
                            end
                            MSG_BIAS, MSG_CONFIG: begin
                                bias_next = in_bias;
                            end
                            MSG_MANUAL: begin
                                for (int i = 0; i < 4; i++) begin
                                    bias_next[i] = '0;
                                end
                                arm_next  = '0;
                                start_req = 1'b1;
                                mode_next = MODE_ARMING_MAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                    MODE_FLYING, MODE_MANUAL: begin
                        hb_next = '0;
                        case (in_msg)
                            MSG_STOP: begin
                                stop_req  = 1'b1;
                                mode_next = MODE_DISARMED;
                            end
                            MSG_ESTOP: begin
                                stop_req  = 1'b1;
                                mode_next = MODE_EMERGENCY;
                            end
                            MSG_BIAS: begin
                                bias_next = in_bias;
                            end
                            MSG_HEARTBEAT, MSG_THROTTLE: begin
                                if (mode_reg == MODE_FLYING) begin
                                    base_thr_next = in_thr;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    MODE_EMERGENCY: begin
                        stop_req = 1'b1;
                        if (in_msg == MSG_RESET) begin
                            mode_next = MODE_DISARMED;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_SAMPLE: begin
                sample_drive = (mode_reg == MODE_FLYING);
            end
            default: begin
            end
        endcase
    end

    // In manual mode the motors follow the biases alone.
    assign thr_s   = (mode_next == MODE_MANUAL) ? 18'sd0 : 18'(base_thr_reg);
    assign pitch_s = (mode_next == MODE_MANUAL) ? 18'sd0 : 18'(in_pitch);
    assign roll_s  = (mode_next == MODE_MANUAL) ? 18'sd0 : 18'(in_roll);
    assign yaw_s   = (mode_next == MODE_MANUAL) ? 18'sd0 : 18'(in_yaw);

    assign mix[0] = thr_s + 18'(bias_next[0]) - pitch_s + yaw_s;
    assign mix[1] = thr_s + 18'(bias_next[1]) + roll_s - yaw_s;
    assign mix[2] = thr_s + 18'(bias_next[2]) - roll_s - yaw_s;
    assign mix[3] = thr_s + 18'(bias_next[3]) + pitch_s + yaw_s;

    always_comb begin
        run_next   = run_reg;
        motor_next = motor_reg;
        if (stop_req || start_req) begin
            run_next = start_req;
            for (int i = 0; i < 4; i++) begin
                motor_next[i] = '0;
            end
        end
        if (sample_drive || mode_next == MODE_MANUAL) begin
            for (int i = 0; i < 4; i++) begin
                motor_next[i] = scale_one(mix[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            hb_timeout_reg <= HB_TIMEOUT_RST;
            arm_delay_reg  <= ARM_DELAY_RST;
            min_thr_reg    <= MIN_THR_RST;
            max_thr_reg    <= MAX_THR_RST;
            mode_reg       <= MODE_INIT;
            hb_reg         <= '0;
            arm_reg        <= '0;
            base_thr_reg   <= BASE_THR_RST;
            run_reg        <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                bias_reg[i]  <= '0;
                motor_reg[i] <= '0;
            end
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_HB_TIMEOUT: hb_timeout_reg <= cfg_data;
                    CFG_ARM_DELAY:  arm_delay_reg  <= cfg_data;
                    CFG_MIN_THR:    min_thr_reg    <= cfg_data[14:0];
                    CFG_MAX_THR:    max_thr_reg    <= cfg_data[14:0];
                    default: begin
                    end
                endcase
            end
            if (advance) begin
                mode_reg     <= mode_next;
                hb_reg       <= hb_next;
                arm_reg      <= arm_next;
                base_thr_reg <= base_thr_next;
                run_reg      <= run_next;
                bias_reg     <= bias_next;
                motor_reg    <= motor_next;
            end
        end
    end

endmodule
